>>> rtl/core/jrpd_pkg.sv
// shared types, constants and register codes for the joint ramp pd torque controller
// no dependencies; every other file refers to this package by scoped names
package jrpd_pkg;

    // default number of joints served by the stores
    localparam int JOINT_COUNT_DEF = 7;

    // q12.20 fixed point
    localparam int FRAC_BITS = 20;

    // setpoint step per tick is speed / 1000 (one millisecond tick)
    localparam int TICK_DIVISOR = 1000;
    // floor(2^41 / 1000), quotient estimate is (speed * recip) >> 41
    localparam logic [31:0] TICK_RECIP = 32'd2199023255;

    // reset value of the torque step limit, 1.0 in q12.20
    localparam logic [30:0] TORQUE_STEP_RESET = 31'd1048576;

    // item function codes
    localparam logic FUNC_START  = 1'b0;
    localparam logic FUNC_UPDATE = 1'b1;

    // configuration port address width, registers at 4*i
    localparam int CFG_ADDR_W = 5;

    // configuration register indexes
    typedef enum logic [2:0] {
        REG_STIFFNESS  = 3'd0,
        REG_DAMPING    = 3'd1,
        REG_VEL_LIMIT  = 3'd2,
        REG_ACCEL      = 3'd3,
        REG_STEP_LIMIT = 3'd4
    } cfg_index_t;

    // input beat
    typedef struct packed {
        logic               func;
        logic [2:0]         joint;
        logic signed [31:0] position;
        logic signed [31:0] velocity;
        logic signed [31:0] coriolis_torque;
        logic signed [31:0] previous_command;
        logic signed [31:0] target_offset;
        logic [20:0]        period;
    } in_t;

    // result beat
    typedef struct packed {
        logic [2:0]         out_joint;
        logic signed [31:0] torque;
        logic               holding;
    } out_t;

    // configuration register contents
    typedef struct packed {
        logic [30:0] stiffness_gain;
        logic [30:0] damping_gain;
        logic [30:0] velocity_limit;
        logic [30:0] accel_rate;
        logic [30:0] torque_step_limit;
    } cfg_t;

    // sequencer commands to the datapath, one strobe per step
    typedef struct packed {
        logic idle;
        logic start;
        logic ramp;
        logic speed;
        logic div;
        logic corr;
        logic law;
        logic err;
        logic mul_d;
        logic mul_p;
        logic sum;
        logic out;
    } dp_cmd_t;

    // datapath status back to the sequencer
    typedef struct packed {
        logic new_start;
        logic new_joint_ok;
        logic out_free;
    } dp_status_t;

endpackage

>>> rtl/core/joint_ramp_pd_torque_controller.sv
// update beat: ramp, speed, div, corr, law, err, mul_d, mul_p, sum and out steps, out waiting
// for a free output, next beat taken back in idle; start beat: joint stores loaded; absent joint: dropped
// rate is set by the sequencer walking the update steps through one shared multiplier
// synchronous active-low reset clears the joint stores, speed and registers to their
// reset values; s_ready is low in reset and rises when the sequencer registers idle
// top level: ties jrpd_regs, jrpd_ctrl and jrpd_dp together; depends on jrpd_pkg
module joint_ramp_pd_torque_controller #(
    parameter int JOINT_COUNT = jrpd_pkg::JOINT_COUNT_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [jrpd_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  jrpd_pkg::in_t                     s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output jrpd_pkg::out_t                    m_data
);

    jrpd_pkg::cfg_t        cfg;
    jrpd_pkg::dp_cmd_t     cmd;
    jrpd_pkg::dp_status_t  status;

    assign s_ready = cmd.idle;

    // configuration registers
    jrpd_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // sequencer
    jrpd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .status  (status),
        .cmd     (cmd)
    );

    // datapath
    jrpd_dp #(
        .JOINT_COUNT (JOINT_COUNT)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .cmd     (cmd),
        .status  (status),
        .s_valid (s_valid),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

>>> rtl/core/jrpd_regs.sv
// apb-style configuration registers for the joint ramp pd torque controller
// depends on jrpd_pkg for the register codes and the cfg_t bundle
module jrpd_regs (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [jrpd_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready,
    output jrpd_pkg::cfg_t                    cfg
);

    jrpd_pkg::cfg_t         cfg_reg;
    jrpd_pkg::cfg_index_t   index;
    logic                   wr_en;

    assign index  = jrpd_pkg::cfg_index_t'(paddr[4:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    // register writes, out-of-range indexes are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.stiffness_gain    <= '0;
            cfg_reg.damping_gain      <= '0;
            cfg_reg.velocity_limit    <= '0;
            cfg_reg.accel_rate        <= '0;
            cfg_reg.torque_step_limit <= jrpd_pkg::TORQUE_STEP_RESET;
        end else if (wr_en) begin
            case (index)
                jrpd_pkg::REG_STIFFNESS:  cfg_reg.stiffness_gain    <= pwdata[30:0];
                jrpd_pkg::REG_DAMPING:    cfg_reg.damping_gain      <= pwdata[30:0];
                jrpd_pkg::REG_VEL_LIMIT:  cfg_reg.velocity_limit    <= pwdata[30:0];
                jrpd_pkg::REG_ACCEL:      cfg_reg.accel_rate        <= pwdata[30:0];
                jrpd_pkg::REG_STEP_LIMIT: cfg_reg.torque_step_limit <= pwdata[30:0];
                default: ;
            endcase
        end
    end

    // read mux
    always_comb begin
        case (index)
            jrpd_pkg::REG_STIFFNESS:  prdata = {1'b0, cfg_reg.stiffness_gain};
            jrpd_pkg::REG_DAMPING:    prdata = {1'b0, cfg_reg.damping_gain};
            jrpd_pkg::REG_VEL_LIMIT:  prdata = {1'b0, cfg_reg.velocity_limit};
            jrpd_pkg::REG_ACCEL:      prdata = {1'b0, cfg_reg.accel_rate};
            jrpd_pkg::REG_STEP_LIMIT: prdata = {1'b0, cfg_reg.torque_step_limit};
            default:                  prdata = '0;
        endcase
    end

endmodule

>>> rtl/core/jrpd_ctrl.sv
// sequencer for the joint ramp pd torque controller
// depends on jrpd_pkg for the command and status bundles
module jrpd_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    input  jrpd_pkg::dp_status_t  status,
    output jrpd_pkg::dp_cmd_t     cmd
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_START,
        ST_RAMP,
        ST_SPEED,
        ST_DIV,
        ST_CORR,
        ST_LAW,
        ST_ERR,
        ST_MUL_D,
        ST_MUL_P,
        ST_SUM,
        ST_OUT
    } state_t;

    state_t              state_reg;
    state_t              state_next;
    jrpd_pkg::dp_cmd_t   cmd_reg;

    assign cmd = cmd_reg;

    // command strobes that go with each state
    function automatic jrpd_pkg::dp_cmd_t cmd_for(input state_t st);
        jrpd_pkg::dp_cmd_t c;
        c = '0;
        case (st)
            ST_IDLE:  c.idle  = 1'b1;
            ST_START: c.start = 1'b1;
            ST_RAMP:  c.ramp  = 1'b1;
            ST_SPEED: c.speed = 1'b1;
            ST_DIV:   c.div   = 1'b1;
            ST_CORR:  c.corr  = 1'b1;
            ST_LAW:   c.law   = 1'b1;
            ST_ERR:   c.err   = 1'b1;
            ST_MUL_D: c.mul_d = 1'b1;
            ST_MUL_P: c.mul_p = 1'b1;
            ST_SUM:   c.sum   = 1'b1;
            ST_OUT:   c.out   = 1'b1;
            default:  c = '0;
        endcase
        return c;
    endfunction

    // next state: update steps in order, out may stall
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid && cmd_reg.idle && status.new_joint_ok) begin
                    state_next = status.new_start ? ST_START : ST_RAMP;
                end
            end
            ST_START: state_next = ST_IDLE;
            ST_RAMP:  state_next = ST_SPEED;
            ST_SPEED: state_next = ST_DIV;
            ST_DIV:   state_next = ST_CORR;
            ST_CORR:  state_next = ST_LAW;
            ST_LAW:   state_next = ST_ERR;
            ST_ERR:   state_next = ST_MUL_D;
            ST_MUL_D: state_next = ST_MUL_P;
            ST_MUL_P: state_next = ST_SUM;
            ST_SUM:   state_next = ST_OUT;
            ST_OUT: begin
                if (status.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // state and registered command outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cmd_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cmd_reg   <= cmd_for(state_next);
        end
    end

endmodule

>>> rtl/core/jrpd_dp.sv
// datapath of the joint ramp pd torque controller: joint stores, shared multiplier,
// divide-by-1000, pd law, torque clamp and the result register; depends on jrpd_pkg
module jrpd_dp #(
    parameter int JOINT_COUNT = jrpd_pkg::JOINT_COUNT_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  jrpd_pkg::cfg_t        cfg,
    input  jrpd_pkg::dp_cmd_t     cmd,
    output jrpd_pkg::dp_status_t  status,
    input  logic                  s_valid,
    input  jrpd_pkg::in_t         s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output jrpd_pkg::out_t        m_data
);

    localparam int IdxW = (JOINT_COUNT > 1) ? $clog2(JOINT_COUNT) : 1;
    localparam logic signed [45:0] SatMax = 46'sd2147483647;
    localparam logic signed [45:0] SatMin = -46'sd2147483648;

    function automatic logic signed [31:0] sat32(input logic signed [45:0] v);
        logic signed [31:0] r;
        if (v > SatMax) begin
            r = 32'sh7FFFFFFF;
        end else if (v < SatMin) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    // per-joint stores
    logic signed [31:0] target_mem [JOINT_COUNT];
    logic signed [31:0] setp_mem   [JOINT_COUNT];

    // control and state registers
    logic [30:0]          desired_reg;
    logic                 m_valid_reg;

    // payload registers
    jrpd_pkg::in_t        item_reg;
    logic signed [42:0]   prod_reg;
    logic [21:0]          q_reg;
    logic signed [32:0]   dist_reg;
    logic signed [22:0]   step_reg;
    logic                 hold_reg;
    logic signed [31:0]   setp_new_reg;
    logic signed [31:0]   err1_reg;
    logic signed [31:0]   err2_reg;
    logic signed [42:0]   pd_reg;
    logic signed [44:0]   tau_reg;
    logic signed [32:0]   hi_reg;
    logic signed [32:0]   lo_reg;
    jrpd_pkg::out_t       out_reg;

    logic                 accept;
    logic                 out_load;
    logic [IdxW-1:0]      jidx;
    logic signed [31:0]   pos;
    logic signed [31:0]   vel;
    logic signed [31:0]   cor;
    logic signed [31:0]   prev;
    logic signed [31:0]   offs;
    logic signed [31:0]   tgt;
    logic signed [31:0]   setp;

    assign accept   = s_valid && cmd.idle;
    assign out_load = cmd.out && (!m_valid_reg || m_ready);
    assign jidx     = IdxW'(item_reg.joint);
    assign pos      = $signed(item_reg.position);
    assign vel      = $signed(item_reg.velocity);
    assign cor      = $signed(item_reg.coriolis_torque);
    assign prev     = $signed(item_reg.previous_command);
    assign offs     = $signed(item_reg.target_offset);
    assign tgt      = target_mem[jidx];
    assign setp     = setp_mem[jidx];

    assign status.new_start    = (s_data.func == jrpd_pkg::FUNC_START);
    assign status.new_joint_ok = (32'(s_data.joint) < JOINT_COUNT);
    assign status.out_free     = !m_valid_reg || m_ready;

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    // shared multiplier: unsigned a times signed b
    logic [31:0]          mul_a;
    logic signed [32:0]   mul_b;
    logic signed [65:0]   mul_full;
    logic                 mul_en;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        if (cmd.ramp) begin
            mul_a = 32'(item_reg.period);
            mul_b = $signed({2'b00, cfg.accel_rate});
        end else if (cmd.div) begin
            mul_a = {1'b0, desired_reg};
            mul_b = $signed({1'b0, jrpd_pkg::TICK_RECIP});
        end else if (cmd.mul_d) begin
            mul_a = {1'b0, cfg.damping_gain};
            mul_b = 33'(err2_reg);
        end else if (cmd.mul_p) begin
            mul_a = {1'b0, cfg.stiffness_gain};
            mul_b = 33'(err1_reg);
        end
    end

    assign mul_en   = cmd.ramp || cmd.div || cmd.mul_d || cmd.mul_p;
    assign mul_full = $signed({1'b0, mul_a}) * mul_b;

    // speed ramp, applied on joint 0 only
    logic [32:0]  speed_sum;
    logic [30:0]  speed_new;

    always_comb begin
        speed_sum = {2'b00, desired_reg};
        if (desired_reg < cfg.velocity_limit) begin
            speed_sum = {2'b00, desired_reg} + {1'b0, prod_reg[31:0]};
        end
        speed_new = (speed_sum > {2'b00, cfg.velocity_limit}) ? cfg.velocity_limit
                                                              : speed_sum[30:0];
    end

    // quotient correction: estimate is exact or one low
    logic [21:0]  q_est;
    logic [31:0]  q_back;
    logic [31:0]  q_rem;

    assign q_est  = prod_reg[42:21];
    assign q_back = 32'(q_est) * 32'(jrpd_pkg::TICK_DIVISOR);
    assign q_rem  = {1'b0, desired_reg} - q_back;

    // step direction and hold decision
    logic signed [32:0]   gap;
    logic signed [32:0]   rem;
    logic [32:0]          rem_abs;
    logic [21:0]          step_mag;
    logic                 opposite;
    logic                 hold;
    logic signed [22:0]   step;

    always_comb begin
        gap      = 33'(tgt) - 33'(pos);
        rem      = 33'(tgt) - 33'(setp);
        rem_abs  = rem[32] ? 33'(-rem) : 33'(rem);
        step_mag = (gap == '0) ? '0 : q_reg;
        opposite = (step_mag != '0) && (rem != '0) && (gap[32] != rem[32]);
        hold     = ({11'b0, step_mag} > rem_abs) && !opposite;
        step     = gap[32] ? -$signed({1'b0, step_mag}) : $signed({1'b0, step_mag});
    end

    // setpoint advance and error terms
    logic signed [32:0]   setp_sum;
    logic signed [31:0]   setp_new;
    logic signed [32:0]   speed_err;
    logic signed [32:0]   track_err;

    assign setp_sum  = 33'(setp) + 33'(step_reg);
    assign setp_new  = sat32(46'(setp_sum));
    assign speed_err = $signed({2'b00, desired_reg}) - 33'(vel);
    assign track_err = 33'(setp_new_reg) - 33'(pos);

    // torque sum, clamp window and final clamp
    logic signed [44:0]   tau_sum;
    logic signed [32:0]   start_sum;
    logic signed [44:0]   tau_clamped;

    always_comb begin
        if (hold_reg) begin
            tau_sum = 45'(cor) + 45'(prod_reg) - 45'(pd_reg);
        end else begin
            tau_sum = 45'(cor) + 45'(prod_reg) + 45'(pd_reg);
        end
        if (tau_reg > 45'(hi_reg)) begin
            tau_clamped = 45'(hi_reg);
        end else if (tau_reg < 45'(lo_reg)) begin
            tau_clamped = 45'(lo_reg);
        end else begin
            tau_clamped = tau_reg;
        end
    end

    assign start_sum = 33'(pos) + 33'(offs);

    // stores, speed and result valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < JOINT_COUNT; i++) begin
                target_mem[i] <= '0;
                setp_mem[i]   <= '0;
            end
            desired_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.start) begin
                target_mem[jidx] <= sat32(46'(start_sum));
                setp_mem[jidx]   <= pos;
                desired_reg      <= '0;
            end
            if (cmd.speed && (item_reg.joint == '0)) begin
                desired_reg <= speed_new;
            end
            if (cmd.err && !hold_reg) begin
                setp_mem[jidx] <= setp_new;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // working registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            item_reg <= s_data;
        end
        if (mul_en) begin
            prod_reg <= mul_full[62:20];
        end
        if (cmd.corr) begin
            q_reg <= (q_rem >= 32'(jrpd_pkg::TICK_DIVISOR)) ? q_est + 22'd1 : q_est;
        end
        if (cmd.law) begin
            dist_reg <= gap;
            step_reg <= step;
            hold_reg <= hold;
        end
        if (cmd.err) begin
            setp_new_reg <= setp_new;
            err2_reg     <= hold_reg ? vel : sat32(46'(speed_err));
        end
        if (cmd.mul_d) begin
            err1_reg <= hold_reg ? sat32(46'(dist_reg)) : sat32(46'(track_err));
        end
        if (cmd.mul_p) begin
            pd_reg <= prod_reg;
        end
        if (cmd.sum) begin
            tau_reg <= tau_sum;
            hi_reg  <= 33'(prev) + $signed({2'b00, cfg.torque_step_limit});
            lo_reg  <= 33'(prev) - $signed({2'b00, cfg.torque_step_limit});
        end
        if (out_load) begin
            out_reg.out_joint <= item_reg.joint;
            out_reg.torque    <= sat32(46'(tau_clamped));
            out_reg.holding   <= hold_reg;
        end
    end

endmodule
